/* hw/rtl/sstf_pkg.sv */
// ----------------------------------------------------------------------------
// sstf_pkg: shared constants for the SSTF disk request scheduler
// Command codes, request kinds and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package sstf_pkg;
  localparam int SLOTS_DEF       = 16;
  localparam int SPT_DEF         = 16;
  localparam int UNITS_DEF       = 2;
  localparam int TRACK_LIMIT_DEF = 1024;

  localparam logic [2:0] CMD_IDLE     = 3'd0;
  localparam logic [2:0] CMD_SEEK     = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_QUERY    = 3'd4;
  localparam logic [2:0] CMD_COMPLETE = 3'd5;
  localparam logic [2:0] CMD_ACCEPTED = 3'd6;
  localparam logic [2:0] CMD_BUSY     = 3'd7;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_NEXT   = 1'b1;

  localparam int SECTOR_SHIFT = 9;
endpackage
`default_nettype wire

/* hw/rtl/sstf_disk_request_scheduler.sv */
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler: shortest-seek-time-first disk scheduler
// Request table with per-unit head state and a sequential slot scan.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item on the in_ ports while busy is low. A
// submit fills a request slot and answers accepted or slot busy. A next
// item asks a unit for its next disk command (seek, read/write sector,
// query, complete or idle). Each item gives one result on the out_ ports,
// marked by out_valid for one cycle; the receiver cannot stall.
// A submit or a next item for an active unit passes the DEC state and
// its result is registered in the output register. A next item for an
// inactive unit scans the table one slot a cycle through a single
// distance compare unit and stops early on a slot at the head's track
// or a size query. busy is high from acceptance until the result
// cycle; the next item can be taken at the edge that ends the result.
// Reset (rst_n low, synchronous) clears all slot valid bits and all per
// unit head state; slot fields are written on submit only.
// ----------------------------------------------------------------------------
`default_nettype none
module sstf_disk_request_scheduler import sstf_pkg::*; #(
  parameter int SLOTS             = SLOTS_DEF,
  parameter int UNITS             = UNITS_DEF,
  parameter int TRACK_LIMIT       = TRACK_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [3:0]  in_slot,
  input  wire logic        in_unit,
  input  wire logic [1:0]  in_request_kind,
  input  wire logic [13:0] in_first_sector,
  input  wire logic [7:0]  in_sector_count,
  output logic             out_valid,
  output logic [2:0]       out_command,
  output logic             out_cmd_unit,
  output logic [9:0]       out_track,
  output logic [3:0]       out_sector,
  output logic [3:0]       out_done_slot,
  output logic [16:0]      out_buffer_offset
);
  localparam int SECTORS_PER_TRACK = SPT_DEF;
  localparam int SW  = $clog2(SLOTS);
  localparam int TW  = $clog2(TRACK_LIMIT);
  localparam int PW  = $clog2(SECTORS_PER_TRACK + 1);
  localparam int UW  = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int CW  = SW + 1;
  localparam int SPW = $clog2(SECTORS_PER_TRACK);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic             s_unit_r  [SLOTS];
  logic [1:0]       s_kind_r  [SLOTS];
  logic [TW-1:0]    s_track_r [SLOTS];
  logic [SPW-1:0]   s_start_r [SLOTS];
  logic [7:0]       s_count_r [SLOTS];

  logic [TW-1:0] head_r [UNITS];
  logic [TW-1:0] head_nxt [UNITS];
  logic          act_r [UNITS];
  logic          act_nxt [UNITS];
  logic [SW-1:0] aslot_r [UNITS];
  logic [SW-1:0] aslot_nxt [UNITS];
  logic [PW-1:0] pos_r [UNITS];
  logic [PW-1:0] pos_nxt [UNITS];
  logic [7:0]    done_r [UNITS];
  logic [7:0]    done_nxt [UNITS];

  logic        op_r;
  logic [3:0]  slot_r;
  logic        unit_r;
  logic [1:0]  kind_r;
  logic [13:0] first_r;
  logic [7:0]  cnt_r;

  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [TW-1:0] bdist_r, bdist_nxt;

  logic          ov_r, ov_nxt;
  logic [2:0]    oc_r, oc_nxt;
  logic          ou_r, ou_nxt;
  logic [9:0]    ot_r, ot_nxt;
  logic [3:0]    os_r, os_nxt;
  logic [3:0]    od_r, od_nxt;
  logic [16:0]   oo_r, oo_nxt;

  logic          wr_en;

  logic [UW-1:0] u;
  logic          unit_ok;
  logic [SW-1:0] si;
  logic          c_ok, c_hit, c_better;
  logic [TW-1:0] c_dist;

  assign u       = UW'(unit_r);
  assign unit_ok = 32'(unit_r) < UNITS;
  assign si      = idx_r[SW-1:0];
  assign c_ok    = valid_r[si] && (UW'(s_unit_r[si]) == u);

  sstf_scan #(.TW(TW)) u_scan (
    .cand_ok    (c_ok),
    .cand_track (s_track_r[si]),
    .cand_kind  (s_kind_r[si]),
    .head       (head_r[u]),
    .found      (found_r),
    .best_dist  (bdist_r),
    .hit        (c_hit),
    .better     (c_better),
    .cand_dist  (c_dist)
  );

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    logic [SW-1:0] s;
    logic [TW-1:0] h;
    state_nxt = state_r;
    valid_nxt = valid_r;
    head_nxt  = head_r;
    act_nxt   = act_r;
    aslot_nxt = aslot_r;
    pos_nxt   = pos_r;
    done_nxt  = done_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    bdist_nxt = bdist_r;
    ov_nxt = 1'b0;
    oc_nxt = oc_r; ou_nxt = ou_r; ot_nxt = ot_r;
    os_nxt = os_r; od_nxt = od_r; oo_nxt = oo_r;
    s = '0;
    h = '0;
    wr_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt = ST_IDLE;
        ov_nxt = 1'b1;
        ou_nxt = unit_r; ot_nxt = '0; os_nxt = '0; oo_nxt = '0;
        if (op_r == OP_SUBMIT) begin
          od_nxt = slot_r;
          if (32'(slot_r) >= SLOTS || !unit_ok || valid_r[SW'(slot_r)]) begin
            oc_nxt = CMD_BUSY;
          end else begin
            oc_nxt = CMD_ACCEPTED;
            valid_nxt[SW'(slot_r)] = 1'b1;
            wr_en = 1'b1;
          end
        end else if (!unit_ok) begin
          oc_nxt = CMD_IDLE; od_nxt = '0;
        end else if (!act_r[u]) begin
          ov_nxt = 1'b0;
          state_nxt = ST_SCAN;
          idx_nxt = '0; found_nxt = 1'b0; best_nxt = '0; bdist_nxt = '1;
        end else begin
          s = aslot_r[u];
          h = head_r[u];
          od_nxt = 4'(s);
          if (s_kind_r[s] == KIND_QUERY && done_r[u] == 8'd0) begin
            done_nxt[u] = 8'd1;
            oc_nxt = CMD_QUERY;
          end else if (s_kind_r[s] != KIND_QUERY && done_r[u] < s_count_r[s]) begin
            if (32'(pos_r[u]) >= SECTORS_PER_TRACK) begin
              h = (32'(h) + 1 >= TRACK_LIMIT) ? '0 : h + 1'b1;
              head_nxt[u] = h;
              pos_nxt[u] = '0;
              oc_nxt = CMD_SEEK;
              ot_nxt = 10'(h);
            end else begin
              oc_nxt = (s_kind_r[s] == KIND_READ) ? CMD_READ : CMD_WRITE;
              ot_nxt = 10'(h);
              os_nxt = 4'(pos_r[u]);
              oo_nxt = 17'(done_r[u]) << SECTOR_SHIFT;
              pos_nxt[u] = pos_r[u] + 1'b1;
              done_nxt[u] = done_r[u] + 8'd1;
            end
          end else begin
            valid_nxt[s] = 1'b0;
            act_nxt[u] = 1'b0;
            oc_nxt = CMD_COMPLETE;
            ot_nxt = 10'(h);
          end
        end
      end
      ST_SCAN: begin
        if (c_hit || 32'(idx_r) == SLOTS - 1) begin
          s = c_hit ? si : (c_better ? si : best_r);
          ov_nxt = 1'b1;
          ou_nxt = unit_r; ot_nxt = '0; os_nxt = '0; oo_nxt = '0;
          state_nxt = ST_IDLE;
          if (!(c_hit || c_better || found_r)) begin
            oc_nxt = CMD_IDLE; od_nxt = '0;
          end else begin
            act_nxt[u] = 1'b1;
            aslot_nxt[u] = s;
            done_nxt[u] = 8'd0;
            pos_nxt[u] = PW'(s_start_r[s]);
            od_nxt = 4'(s);
            if (s_kind_r[s] != KIND_QUERY && s_track_r[s] != head_r[u]) begin
              head_nxt[u] = s_track_r[s];
              oc_nxt = CMD_SEEK;
              ot_nxt = 10'(s_track_r[s]);
            end else if (s_kind_r[s] == KIND_QUERY) begin
              done_nxt[u] = 8'd1;
              oc_nxt = CMD_QUERY;
            end else if (s_count_r[s] != 8'd0) begin
              oc_nxt = (s_kind_r[s] == KIND_READ) ? CMD_READ : CMD_WRITE;
              ot_nxt = 10'(head_r[u]);
              os_nxt = 4'(s_start_r[s]);
              pos_nxt[u] = PW'(s_start_r[s]) + 1'b1;
              done_nxt[u] = 8'd1;
            end else begin
              valid_nxt[s] = 1'b0;
              act_nxt[u] = 1'b0;
              oc_nxt = CMD_COMPLETE;
              ot_nxt = 10'(head_r[u]);
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (c_better) begin
            found_nxt = 1'b1; best_nxt = si; bdist_nxt = c_dist;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < UNITS; i++) begin
        head_r[i] <= '0; act_r[i] <= 1'b0; aslot_r[i] <= '0;
        pos_r[i] <= '0; done_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
      head_r  <= head_nxt;
      act_r   <= act_nxt;
      aslot_r <= aslot_nxt;
      pos_r   <= pos_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r <= in_opcode; slot_r <= in_slot; unit_r <= in_unit;
      kind_r <= in_request_kind; first_r <= in_first_sector; cnt_r <= in_sector_count;
    end
    idx_r <= idx_nxt; found_r <= found_nxt; best_r <= best_nxt; bdist_r <= bdist_nxt;
    oc_r <= oc_nxt; ou_r <= ou_nxt; ot_r <= ot_nxt;
    os_r <= os_nxt; od_r <= od_nxt; oo_r <= oo_nxt;
  end

  logic [13:0] f_trk;
  logic [TW-1:0] f_sat;
  assign f_trk = first_r >> SPW;
  assign f_sat = (32'(f_trk) >= TRACK_LIMIT) ? TW'(TRACK_LIMIT - 1) : TW'(f_trk);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      s_unit_r[SW'(slot_r)] <= unit_r;
      if (kind_r[1]) begin
        s_kind_r[SW'(slot_r)]  <= KIND_QUERY;
        s_track_r[SW'(slot_r)] <= '0;
        s_start_r[SW'(slot_r)] <= '0;
        s_count_r[SW'(slot_r)] <= '0;
      end else begin
        s_kind_r[SW'(slot_r)]  <= kind_r;
        s_track_r[SW'(slot_r)] <= f_sat;
        s_start_r[SW'(slot_r)] <= first_r[SPW-1:0];
        s_count_r[SW'(slot_r)] <= cnt_r;
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_command       = oc_r;
  assign out_cmd_unit      = ou_r;
  assign out_track         = ot_r;
  assign out_sector        = os_r;
  assign out_done_slot     = od_r;
  assign out_buffer_offset = oo_r;
endmodule
`default_nettype wire

/* hw/rtl/sstf_scan.sv */
// ----------------------------------------------------------------------------
// sstf_scan: one-slot-per-cycle nearest track compare step
// Compares one candidate slot against the best one found so far.
// ----------------------------------------------------------------------------
`default_nettype none
module sstf_scan import sstf_pkg::*; #(
  parameter int TW = 10
) (
  input  wire logic          cand_ok,
  input  wire logic [TW-1:0] cand_track,
  input  wire logic [1:0]    cand_kind,
  input  wire logic [TW-1:0] head,
  input  wire logic          found,
  input  wire logic [TW-1:0] best_dist,
  output logic               hit,
  output logic               better,
  output logic [TW-1:0]      cand_dist
);
  always_comb begin
    cand_dist = (cand_track > head) ? cand_track - head : head - cand_track;
    hit       = cand_ok && (cand_track == head || cand_kind == KIND_QUERY);
    better    = cand_ok && (!found || cand_dist < best_dist);
  end
endmodule
`default_nettype wire

/* dv/sstf_disk_request_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_tb: self-checking bench for the SSTF scheduler
// Drives submit and next items with random gaps, predicts every command
// with a behavioral model of the request table and head state, and compares
// each result as a whole against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sstf_disk_request_scheduler_tb;
  import sstf_pkg::*;

  localparam int NSLOT = 16;
  localparam int SPT   = 16;
  localparam int NUNIT = 2;
  localparam int TLIM  = 1024;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  command;
    logic        cmd_unit;
    logic [9:0]  track;
    logic [3:0]  sector;
    logic [3:0]  done_slot;
    logic [16:0] offset;
  } disk_cmd_t;

  class sched_scoreboard;
    bit         valid [NSLOT];
    bit         sunit [NSLOT];
    bit [1:0]   skind [NSLOT];
    bit [9:0]   strack[NSLOT];
    bit [4:0]   sstart[NSLOT];
    bit [7:0]   scount[NSLOT];
    bit [9:0]   head  [NUNIT];
    bit         active[NUNIT];
    bit [3:0]   aslot [NUNIT];
    bit [4:0]   spos  [NUNIT];
    bit [8:0]   sdone [NUNIT];
    disk_cmd_t  pending[$];
    int         errors;
    int         checked;
    int         seeks, xfers, queries, completes, idles, refusals;

    function disk_cmd_t mk(bit [2:0] c, bit u, bit [9:0] t, bit [3:0] s,
                           bit [3:0] sl, bit [16:0] o);
      disk_cmd_t r;
      r.command = c; r.cmd_unit = u; r.track = t; r.sector = s;
      r.done_slot = sl; r.offset = o;
      return r;
    endfunction

    function disk_cmd_t serve(bit u);
      bit [3:0] s;
      disk_cmd_t r;
      s = aslot[u];
      if (skind[s] == KIND_QUERY) begin
        if (sdone[u] == 0) begin
          sdone[u] = 1;
          return mk(CMD_QUERY, u, 0, 0, s, 0);
        end
      end else if (sdone[u] < scount[s]) begin
        if (spos[u] >= SPT) begin
          head[u] = (head[u] + 1 >= TLIM) ? 10'd0 : head[u] + 10'd1;
          spos[u] = 0;
          return mk(CMD_SEEK, u, head[u], 0, s, 0);
        end
        r = mk(CMD_READ + skind[s], u, head[u], spos[u][3:0], s,
               17'(sdone[u]) * 17'd512);
        spos[u]++;
        sdone[u]++;
        return r;
      end
      valid[s] = 0;
      active[u] = 0;
      return mk(CMD_COMPLETE, u, head[u], 0, s, 0);
    endfunction

    function disk_cmd_t next_cmd(bit u);
      int best, bestd, d;
      bit found;
      best = 0; bestd = 32'h7fffffff; found = 0;
      if (!active[u]) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!valid[i] || sunit[i] != u) continue;
          if (strack[i] == head[u] || skind[i] == KIND_QUERY) begin
            best = i; found = 1; break;
          end
          d = strack[i] > head[u] ? strack[i] - head[u] : head[u] - strack[i];
          if (d < bestd) begin
            bestd = d; best = i; found = 1;
          end
        end
        if (!found) return mk(CMD_IDLE, u, 0, 0, 0, 0);
        active[u] = 1;
        aslot[u] = 4'(best);
        sdone[u] = 0;
        spos[u] = sstart[best];
        if (skind[best] != KIND_QUERY && strack[best] != head[u]) begin
          head[u] = strack[best];
          return mk(CMD_SEEK, u, head[u], 0, 4'(best), 0);
        end
      end
      return serve(u);
    endfunction

    function void note_item(bit op, bit [3:0] sl, bit u, bit [1:0] k,
                            bit [13:0] first, bit [7:0] cnt);
      disk_cmd_t r;
      int t;
      if (op == OP_NEXT) r = next_cmd(u);
      else if (valid[sl]) r = mk(CMD_BUSY, u, 0, 0, sl, 0);
      else begin
        valid[sl] = 1;
        sunit[sl] = u;
        if (k[1]) begin
          skind[sl] = KIND_QUERY; strack[sl] = 0; sstart[sl] = 0; scount[sl] = 0;
        end else begin
          t = first / SPT;
          if (t >= TLIM) t = TLIM - 1;
          skind[sl] = k; strack[sl] = 10'(t); sstart[sl] = 5'(first % SPT);
          scount[sl] = cnt;
        end
        r = mk(CMD_ACCEPTED, u, 0, 0, sl, 0);
      end
      case (r.command)
        CMD_SEEK: seeks++;
        CMD_READ, CMD_WRITE: xfers++;
        CMD_QUERY: queries++;
        CMD_COMPLETE: completes++;
        CMD_IDLE: idles++;
        CMD_BUSY: refusals++;
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_cmd(disk_cmd_t got);
      disk_cmd_t exp;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d mismatch exp %p got %p", checked, exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_opcode = 0;
  logic [3:0] in_slot = 0;
  logic in_unit = 0;
  logic [1:0] in_request_kind = 0;
  logic [13:0] in_first_sector = 0;
  logic [7:0] in_sector_count = 0;
  logic out_valid;
  logic [2:0] out_command;
  logic out_cmd_unit;
  logic [9:0] out_track;
  logic [3:0] out_sector, out_done_slot;
  logic [16:0] out_buffer_offset;

  sched_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 0;

  always #2 clk = ~clk;

  sstf_disk_request_scheduler dut (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_slot, .in_unit,
    .in_request_kind, .in_first_sector, .in_sector_count, .out_valid,
    .out_command, .out_cmd_unit, .out_track, .out_sector, .out_done_slot,
    .out_buffer_offset
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      sb.check_cmd({out_command, out_cmd_unit, out_track, out_sector,
                    out_done_slot, out_buffer_offset});
    if (rst_n && start && !busy)
      sb.note_item(in_opcode, in_slot, in_unit, in_request_kind,
                   in_first_sector, in_sector_count);
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(bit op, bit [3:0] sl, bit u, bit [1:0] k,
                      bit [13:0] first, bit [7:0] cnt);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_opcode <= op; in_slot <= sl; in_unit <= u; in_request_kind <= k;
    in_first_sector <= first; in_sector_count <= cnt;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic nxt(bit u);
    send(OP_NEXT, 4'($urandom), u, 2'($urandom), 14'($urandom), 8'($urandom));
  endtask

  task automatic submit_rand(bit u, bit [3:0] sl);
    bit [7:0] cnt;
    cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    send(OP_SUBMIT, sl, u, 2'($urandom), 14'($urandom), cnt);
  endtask

  initial begin
    int n;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: empty unit, extremes, query, busy slot, zero count, wrap
    nxt(0);
    send(OP_SUBMIT, 4'd15, 1, KIND_READ, 14'h3FFF, 8'd20);
    send(OP_SUBMIT, 4'd15, 1, KIND_READ, 0, 0);
    send(OP_SUBMIT, 4'd0, 0, 2'd1, 14'd0, 8'd0);
    send(OP_SUBMIT, 4'd1, 0, 2'd3, 14'h3FFF, 8'hFF);
    send(OP_SUBMIT, 4'd2, 0, KIND_QUERY, 14'd100, 8'd5);
    send(OP_SUBMIT, 4'd3, 0, 2'd1, 14'd47, 8'd3);
    repeat (12) nxt(0);
    repeat (24) nxt(1);
    nxt(1);
    n = 0;
    while (n < 560) begin
      if ($urandom_range(0, 9) < 6) begin
        submit_rand(1'($urandom), 4'($urandom_range(0, 15)));
      end else begin
        nxt(1'($urandom));
      end
      n++;
      if (n > 460) quiet = 1;
    end
    // work off pending requests
    repeat (100) nxt(1'($urandom));
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d results: %0d seeks, %0d transfers, %0d queries, %0d completes,",
             sb.checked, sb.seeks, sb.xfers, sb.queries, sb.completes);
    $display("%0d idle answers, %0d refused submits", sb.idles, sb.refusals);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_scan.sv
hw/rtl/sstf_disk_request_scheduler.sv
dv/sstf_disk_request_scheduler_tb.sv
